/* src/tlc_pkg.sv */
package tlc_pkg;

    localparam int L1_ENTRIES = 16;
    localparam int L2_ENTRIES = 128;
    localparam int L1_IW = $clog2(L1_ENTRIES);
    localparam int L2_IW = $clog2(L2_ENTRIES);
    localparam int L2_CW = $clog2(L2_ENTRIES + 1);

    typedef struct packed {
        logic load;
        logic l1_lookup;
        logic l2_lookup;
        logic l2_step;
        logic l1_hit_upd;
        logic l1_fill;
        logic l2_fill;
        logic binv_chk;
        logic done;
    } tlc_cmd_t;

    typedef struct packed {
        logic l1_match;
        logic l2_match;
        logic l2_scan_last;
    } tlc_stat_t;

endpackage

/* src/two_level_inclusive_lru_cache.sv */
// Two-level inclusive LRU cache: a 16-entry L1 kept inside a 128-entry L2.
// Input channel s_*: one memory access per request; tdata = {addr, inst_id}.
// Output channel m_*: one result per request. tdata holds inst_id_out,
// l1_miss_total, l2_miss_total; tuser holds l1_hit, l2_hit, back_invalidated.
// An L1 hit is answered straight from the L1 lookup. An L1 miss walks the L2
// tags one entry a cycle through a registered read, then fills the L1 and,
// on an L2 miss, the L2 as well, and checks the L1 for back-invalidation.
// One request is in flight at a time; s_tready is high only while idle and
// the next request can be taken in the cycle after the result is accepted.
// L2 recency moves only on fills, so once the L2 is full a round-robin
// pointer names its LRU victim.
// A stalled result holds on m_* until m_tready; no new request is taken.
// Reset clears the L1 valid bits and ages, the L2 fill count and pointer,
// and both miss totals; the tag stores are not cleared.
module two_level_inclusive_lru_cache
    import tlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // inst_id[31:0], addr[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // inst_id_out[31:0], l1_miss_total[63:32], l2_miss_total[95:64]
    output logic [2:0]  m_tuser    // l1_hit[0], l2_hit[1], back_invalidated[2]
);

    tlc_cmd_t  cmd;
    tlc_stat_t stat;

    tlc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd)
    );

    tlc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_tdata(s_tdata), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

endmodule

/* src/tlc_ctrl.sv */
module tlc_ctrl
    import tlc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  tlc_stat_t stat,
    output tlc_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_L1   = 3'd1;
    localparam logic [2:0] ST_L2   = 3'd2;
    localparam logic [2:0] ST_L2F  = 3'd3;
    localparam logic [2:0] ST_BINV = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_L1;
                end
            end
            ST_L1: begin
                cmd.l1_lookup = 1'b1;
                state_next = ST_L2;
            end
            ST_L2: begin
                if (stat.l1_match) begin
                    cmd.l1_hit_upd = 1'b1;
                    cmd.done = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.l2_step = 1'b1;
                    if (stat.l2_scan_last) begin
                        cmd.l2_lookup = 1'b1;
                        state_next = ST_L2F;
                    end
                end
            end
            ST_L2F: begin
                cmd.l1_fill = 1'b1;
                if (stat.l2_match) begin
                    cmd.done = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.l2_fill = 1'b1;
                    state_next = ST_BINV;
                end
            end
            ST_BINV: begin
                cmd.binv_chk = 1'b1;
                cmd.done = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_load_l1: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_L1) else $error("load sequence");

endmodule

/* src/tlc_dp.sv */
module tlc_dp
    import tlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tlc_cmd_t    cmd,
    output tlc_stat_t   stat,
    input  logic [63:0] s_tdata,
    output logic [95:0] m_tdata,
    output logic [2:0]  m_tuser
);

    logic [31:0] l1_tag_reg [L1_ENTRIES];
    logic [L1_ENTRIES-1:0] l1_valid_reg;
    logic [L1_IW-1:0] l1_age_reg [L1_ENTRIES];
    logic [31:0] l2_tag_mem [L2_ENTRIES];
    logic [L2_CW-1:0] l2_used_reg;
    logic [L2_IW-1:0] l2_ptr_reg;

    logic [31:0] id_reg, addr_reg, l1_miss_reg, l2_miss_reg;
    logic l1_hit_reg, l2_hit_reg, binv_reg, l2_found_reg;
    logic [L1_IW-1:0] l1_idx_reg;
    logic [L2_IW-1:0] scan_reg, l2_rd_idx_reg;
    logic scan_done_reg, scan_rd_reg;
    logic [31:0] l2_rd_tag_reg;
    logic [31:0] victim_reg;
    logic l2_evict_reg;

    logic l1_match, l1_have_free, binv_match;
    logic [L1_IW-1:0] l1_midx, l1_lru, l1_free, binv_idx, l1_slot;
    logic l2_full, l2_rd_valid;
    logic [L2_IW-1:0] l2_slot, l2_last;

    always_comb begin
        l1_match = 1'b0;
        l1_midx = '0;
        binv_match = 1'b0;
        binv_idx = '0;
        l1_lru = '0;
        l1_free = '0;
        l1_have_free = 1'b0;
        for (int i = 0; i < L1_ENTRIES; i++) begin
            if (l1_valid_reg[i] && l1_tag_reg[i] == addr_reg) begin
                l1_match = 1'b1;
                l1_midx = L1_IW'(i);
            end
            if (l1_valid_reg[i] && l1_tag_reg[i] == victim_reg) begin
                binv_match = 1'b1;
                binv_idx = L1_IW'(i);
            end
            if (l1_valid_reg[i] && l1_age_reg[i] == L1_IW'(L1_ENTRIES - 1))
                l1_lru = L1_IW'(i);
        end
        for (int i = L1_ENTRIES - 1; i >= 0; i--) begin
            if (!l1_valid_reg[i]) begin
                l1_have_free = 1'b1;
                l1_free = L1_IW'(i);
            end
        end
    end

    assign l1_slot = l1_have_free ? l1_free : l1_lru;

    // L2 recency moves only on fills: the LRU entry is the oldest fill
    assign l2_last = L2_IW'(L2_ENTRIES - 1);
    assign l2_full = (l2_used_reg == L2_CW'(L2_ENTRIES));
    assign l2_rd_valid = (L2_CW'(l2_rd_idx_reg) < l2_used_reg);
    assign l2_slot = l2_full ? l2_ptr_reg : l2_used_reg[L2_IW-1:0];

    assign stat.l1_match = l1_hit_reg;
    assign stat.l2_match = l2_found_reg;
    assign stat.l2_scan_last = scan_rd_reg && (l2_rd_idx_reg == l2_last);

    always_ff @(posedge aclk) begin
        if (cmd.l2_step && !scan_done_reg) l2_rd_tag_reg <= l2_tag_mem[scan_reg];
        if (cmd.l2_fill) l2_tag_mem[l2_slot] <= addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg <= '0;
            for (int i = 0; i < L1_ENTRIES; i++) l1_age_reg[i] <= '0;
            l2_used_reg <= '0;
            l2_ptr_reg <= '0;
            l1_miss_reg <= '0;
            l2_miss_reg <= '0;
            id_reg <= '0;
            addr_reg <= '0;
            l1_hit_reg <= 1'b0;
            l2_hit_reg <= 1'b0;
            binv_reg <= 1'b0;
            l2_found_reg <= 1'b0;
            l2_evict_reg <= 1'b0;
            l1_idx_reg <= '0;
            l2_rd_idx_reg <= '0;
            victim_reg <= '0;
            scan_reg <= '0;
            scan_done_reg <= 1'b0;
            scan_rd_reg <= 1'b0;
        end else begin
            scan_rd_reg <= cmd.l2_step && !scan_done_reg;
            if (cmd.load) begin
                id_reg <= s_tdata[31:0];
                addr_reg <= s_tdata[63:32];
                l1_hit_reg <= 1'b0;
                l2_hit_reg <= 1'b0;
                binv_reg <= 1'b0;
                l2_found_reg <= 1'b0;
                scan_reg <= '0;
                scan_done_reg <= 1'b0;
            end
            if (cmd.l1_lookup) begin
                l1_hit_reg <= l1_match;
                l1_idx_reg <= l1_midx;
            end
            if (cmd.l2_step && !scan_done_reg) begin
                l2_rd_idx_reg <= scan_reg;
                if (scan_reg == l2_last) scan_done_reg <= 1'b1;
                else scan_reg <= scan_reg + 1'b1;
            end
            if (scan_rd_reg) begin
                if (l2_rd_valid && l2_rd_tag_reg == addr_reg) l2_found_reg <= 1'b1;
                if (l2_rd_idx_reg == l2_ptr_reg) victim_reg <= l2_rd_tag_reg;
            end
            if (cmd.l1_hit_upd) begin
                for (int i = 0; i < L1_ENTRIES; i++)
                    if (l1_valid_reg[i] && l1_age_reg[i] < l1_age_reg[l1_idx_reg])
                        l1_age_reg[i] <= l1_age_reg[i] + 1'b1;
                l1_age_reg[l1_idx_reg] <= '0;
            end
            if (cmd.l2_lookup && l1_miss_reg != '1) l1_miss_reg <= l1_miss_reg + 1'b1;
            if (cmd.l1_fill) begin
                for (int i = 0; i < L1_ENTRIES; i++)
                    if (l1_valid_reg[i] && (l1_have_free || l1_lru != L1_IW'(i)))
                        l1_age_reg[i] <= l1_age_reg[i] + 1'b1;
                l1_tag_reg[l1_slot] <= addr_reg;
                l1_valid_reg[l1_slot] <= 1'b1;
                l1_age_reg[l1_slot] <= '0;
                l2_hit_reg <= l2_found_reg;
            end
            if (cmd.l2_fill) begin
                if (l2_miss_reg != '1) l2_miss_reg <= l2_miss_reg + 1'b1;
                l2_evict_reg <= l2_full;
                if (l2_full) l2_ptr_reg <= (l2_ptr_reg == l2_last) ? '0 : l2_ptr_reg + 1'b1;
                else l2_used_reg <= l2_used_reg + 1'b1;
            end
            if (cmd.binv_chk && l2_evict_reg && binv_match) begin
                l1_valid_reg[binv_idx] <= 1'b0;
                binv_reg <= 1'b1;
                for (int j = 0; j < L1_ENTRIES; j++)
                    if (l1_valid_reg[j] && l1_age_reg[j] > l1_age_reg[binv_idx])
                        l1_age_reg[j] <= l1_age_reg[j] - 1'b1;
            end
        end
    end

    assign m_tdata = {l2_miss_reg, l1_miss_reg, id_reg};
    assign m_tuser = {binv_reg, l2_hit_reg, l1_hit_reg};

    a_l2_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        l2_used_reg <= L2_CW'(L2_ENTRIES)) else $error("l2 count overflow");
    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |=> !(l1_hit_reg && l2_hit_reg)) else $error("both hits");
    a_binv: assert property (@(posedge aclk) disable iff (!aresetn)
        binv_reg |-> !l1_hit_reg) else $error("binv on l1 hit");
    a_ptr_full: assert property (@(posedge aclk) disable iff (!aresetn)
        l2_ptr_reg != '0 |-> l2_full) else $error("pointer moved before full");

endmodule
